/* src/v3a_pkg.sv */
// Shared types, opcodes and the saturation helper for the 3D vector ALU.
// No dependencies; every other file in src imports this package.
package v3a_pkg;

    typedef logic signed [31:0] fix_t;

    // Input beat
    typedef struct packed {
        logic [2:0]         func;
        fix_t               first_x;
        fix_t               first_y;
        fix_t               first_z;
        fix_t               second_x;
        fix_t               second_y;
        fix_t               second_z;
        logic signed [15:0] divisor;
    } in_t;

    // Result beat
    typedef struct packed {
        fix_t       result_x;
        fix_t       result_y;
        fix_t       result_z;
        fix_t       scalar;
        logic [1:0] status;
    } out_t;

    // Per-item sideband carried alongside the square root and divider
    typedef struct packed {
        logic [2:0]         func;
        fix_t [2:0]         a;
        logic signed [15:0] divisor;
        fix_t [2:0]         res;
        fix_t               res_s;
        logic               sat;
        logic [31:0]        root;
    } side_t;

    // Opcodes
    localparam logic [2:0] FN_DOT   = 3'd0;
    localparam logic [2:0] FN_CROSS = 3'd1;
    localparam logic [2:0] FN_NORM  = 3'd2;
    localparam logic [2:0] FN_MAG   = 3'd3;
    localparam logic [2:0] FN_ADD   = 3'd4;
    localparam logic [2:0] FN_DIV   = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_ERR = 2'd2;

    localparam int CLIP_W = 68;

    // Clip a wide signed value to the 32-bit range, flag when clipped
    function automatic fix_t clip32(input logic signed [CLIP_W-1:0] v, output logic sat);
        logic signed [CLIP_W-1:0] hi;
        logic signed [CLIP_W-1:0] lo;
        hi = CLIP_W'(64'sh7FFF_FFFF);
        lo = -CLIP_W'(64'sh8000_0000);
        sat = 1'b0;
        if (v > hi) begin
            sat = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < lo) begin
            sat = 1'b1;
            return 32'sh8000_0000;
        end
        return fix_t'(v[31:0]);
    endfunction

endpackage

/* src/v3a_isqrt.sv */
// Pipelined integer square root, one root bit per stage (32 stages).
// Depends on v3a_pkg for the sideband type carried with each beat.
module v3a_isqrt import v3a_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  side_t       in_side,
    input  logic [63:0] in_rad,
    output logic        out_valid,
    output side_t       out_side,
    output logic [31:0] out_root
);

    localparam int NST = 32;

    logic        vld_reg  [1:NST];
    side_t       side_reg [1:NST];
    logic [63:0] rad_reg  [1:NST];
    logic [32:0] rem_reg  [1:NST];
    logic [31:0] root_reg [1:NST];

    for (genvar k = 0; k < NST; k++) begin : g_st
        localparam int J = NST - 1 - k;
        logic        src_v;
        side_t       src_side;
        logic [63:0] src_rad;
        logic [32:0] src_rem;
        logic [31:0] src_root;
        logic [34:0] cand;
        logic [34:0] trial;
        logic [32:0] rem_next;
        logic [31:0] root_next;

        if (k == 0) begin : g_first
            assign src_v    = in_valid;
            assign src_side = in_side;
            assign src_rad  = in_rad;
            assign src_rem  = '0;
            assign src_root = '0;
        end else begin : g_rest
            assign src_v    = vld_reg[k];
            assign src_side = side_reg[k];
            assign src_rad  = rad_reg[k];
            assign src_rem  = rem_reg[k];
            assign src_root = root_reg[k];
        end

        // Bring down the next bit pair and try the trial subtraction
        // (remainder stays below 2*root + 1, so 33 bits hold it)
        always_comb begin
            cand  = {src_rem, src_rad[2*J+1 -: 2]};
            trial = {1'b0, src_root, 2'b01};
            if (cand >= trial) begin
                rem_next  = 33'(cand - trial);
                root_next = {src_root[30:0], 1'b1};
            end else begin
                rem_next  = cand[32:0];
                root_next = {src_root[30:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= src_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k+1] <= src_side;
                rad_reg[k+1]  <= src_rad;
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= root_next;
            end
        end
    end

    assign out_valid = vld_reg[NST];
    assign out_side  = side_reg[NST];
    assign out_root  = root_reg[NST];

endmodule

/* src/v3a_div.sv */
// Three-lane pipelined restoring divider, one quotient bit per stage.
// Depends on v3a_pkg; quotient must fit 32 bits (caller guarantees).
module v3a_div import v3a_pkg::*; #(
    parameter int DW = 48
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  side_t                in_side,
    input  logic [2:0][DW-1:0]   in_num,
    input  logic [31:0]          in_den,
    output logic                 out_valid,
    output side_t                out_side,
    output logic [2:0][31:0]     out_quo
);

    localparam int NST = 32;

    logic            vld_reg  [1:NST];
    side_t           side_reg [1:NST];
    logic [31:0]     den_reg  [1:NST];
    logic [2:0][31:0] num_reg [1:NST];
    logic [2:0][31:0] rem_reg [1:NST];
    logic [2:0][31:0] quo_reg [1:NST];

    for (genvar k = 0; k < NST; k++) begin : g_st
        localparam int B = NST - 1 - k;
        logic             src_v;
        side_t            src_side;
        logic [31:0]      src_den;
        logic [2:0][31:0] src_num;
        logic [2:0][31:0] src_rem;
        logic [2:0][31:0] src_quo;
        logic [2:0][31:0] rem_next;
        logic [2:0][31:0] quo_next;

        if (k == 0) begin : g_first
            assign src_v    = in_valid;
            assign src_side = in_side;
            assign src_den  = in_den;
            for (genvar i = 0; i < 3; i++) begin : g_ln
                assign src_num[i] = in_num[i][31:0];
                assign src_rem[i] = 32'(in_num[i][DW-1:32]);
                assign src_quo[i] = '0;
            end
        end else begin : g_rest
            assign src_v    = vld_reg[k];
            assign src_side = side_reg[k];
            assign src_den  = den_reg[k];
            assign src_num  = num_reg[k];
            assign src_rem  = rem_reg[k];
            assign src_quo  = quo_reg[k];
        end

        // Shift in one dividend bit per lane and subtract when it fits
        always_comb begin
            logic [32:0] cand;
            for (int i = 0; i < 3; i++) begin
                cand = {src_rem[i], src_num[i][B]};
                if (cand >= {1'b0, src_den}) begin
                    rem_next[i] = 32'(cand - {1'b0, src_den});
                    quo_next[i] = {src_quo[i][30:0], 1'b1};
                end else begin
                    rem_next[i] = cand[31:0];
                    quo_next[i] = {src_quo[i][30:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= src_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k+1] <= src_side;
                den_reg[k+1]  <= src_den;
                num_reg[k+1]  <= src_num;
                rem_reg[k+1]  <= rem_next;
                quo_reg[k+1]  <= quo_next;
            end
        end
    end

    assign out_valid = vld_reg[NST];
    assign out_side  = side_reg[NST];
    assign out_quo   = quo_reg[NST];

endmodule

/* src/vec3_alu.sv */
// 3D vector ALU top level: multiply, sum, clip, square root, divide, output.
// Depends on v3a_pkg, v3a_isqrt and v3a_div.
// Pipeline: 70 register stages (4 front, 32 square-root, 1 setup, 32 divider,
// output register).
// Throughput: one beat per cycle; the whole pipeline holds when the output stalls.
// Reset: aresetn synchronous active low clears all valid bits; data is not reset.
module vec3_alu import v3a_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int DW = 32 + FRAC_BITS;

    logic en;
    logic m_valid_reg;
    out_t m_data_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Stage 0: input capture
    logic in_valid_reg;
    in_t  in_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg <= s_data;
        end
    end

    // Stage 1: products (dot lanes square A for norm and magnitude)
    logic                     p1_valid_reg;
    in_t                      p1_item_reg;
    logic signed [2:0][63:0]  p1_dot_reg;
    logic signed [5:0][63:0]  p1_cr_reg;
    logic signed [2:0][63:0]  p1_dot_next;
    logic signed [5:0][63:0]  p1_cr_next;
    fix_t [2:0] va;
    fix_t [2:0] vb;
    fix_t [2:0] vm;
    logic       sq_sel;

    always_comb begin
        va = {in_reg.first_z, in_reg.first_y, in_reg.first_x};
        vb = {in_reg.second_z, in_reg.second_y, in_reg.second_x};
        sq_sel = (in_reg.func == FN_NORM) || (in_reg.func == FN_MAG);
        vm = sq_sel ? va : vb;
        for (int i = 0; i < 3; i++) begin
            p1_dot_next[i] = $signed(va[i]) * $signed(vm[i]);
        end
        p1_cr_next[0] = $signed(va[1]) * $signed(vb[2]);
        p1_cr_next[1] = $signed(va[2]) * $signed(vb[1]);
        p1_cr_next[2] = $signed(va[2]) * $signed(vb[0]);
        p1_cr_next[3] = $signed(va[0]) * $signed(vb[2]);
        p1_cr_next[4] = $signed(va[0]) * $signed(vb[1]);
        p1_cr_next[5] = $signed(va[1]) * $signed(vb[0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_item_reg <= in_reg;
            p1_dot_reg  <= p1_dot_next;
            p1_cr_reg   <= p1_cr_next;
        end
    end

    // Stage 2: exact sums and differences
    logic              p2_valid_reg;
    in_t               p2_item_reg;
    logic signed [65:0] p2_dot_reg;
    logic signed [64:0] p2_cr_reg [3];
    logic signed [32:0] p2_add_reg [3];
    logic signed [65:0] p2_dot_next;
    logic signed [64:0] p2_cr_next [3];
    logic signed [32:0] p2_add_next [3];

    always_comb begin
        p2_dot_next = 66'($signed(p1_dot_reg[0])) + 66'($signed(p1_dot_reg[1]))
                    + 66'($signed(p1_dot_reg[2]));
        p2_cr_next[0] = 65'($signed(p1_cr_reg[0])) - 65'($signed(p1_cr_reg[1]));
        p2_cr_next[1] = 65'($signed(p1_cr_reg[2])) - 65'($signed(p1_cr_reg[3]));
        p2_cr_next[2] = 65'($signed(p1_cr_reg[4])) - 65'($signed(p1_cr_reg[5]));
        p2_add_next[0] = 33'(p1_item_reg.first_x) + 33'(p1_item_reg.second_x);
        p2_add_next[1] = 33'(p1_item_reg.first_y) + 33'(p1_item_reg.second_y);
        p2_add_next[2] = 33'(p1_item_reg.first_z) + 33'(p1_item_reg.second_z);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_item_reg <= p1_item_reg;
            p2_dot_reg  <= p2_dot_next;
            p2_cr_reg   <= p2_cr_next;
            p2_add_reg  <= p2_add_next;
        end
    end

    // Stage 3: floor shift and clip of dot, cross and add
    logic        p3_valid_reg;
    side_t       p3_side_reg;
    logic [63:0] p3_rad_reg;
    side_t       p3_side_next;

    always_comb begin
        logic signed [65:0] dot_sh;
        logic signed [64:0] cr_sh;
        logic               s;
        fix_t               v;
        s     = 1'b0;
        v     = '0;
        cr_sh = '0;
        dot_sh = p2_dot_reg >>> FRAC_BITS;
        p3_side_next.func    = p2_item_reg.func;
        p3_side_next.a       = {p2_item_reg.first_z, p2_item_reg.first_y,
                                p2_item_reg.first_x};
        p3_side_next.divisor = p2_item_reg.divisor;
        p3_side_next.res     = '0;
        p3_side_next.res_s   = '0;
        p3_side_next.sat     = 1'b0;
        p3_side_next.root    = '0;
        unique case (p2_item_reg.func)
            FN_DOT: begin
                v = clip32(CLIP_W'(dot_sh), s);
                p3_side_next.res_s = v;
                p3_side_next.sat   = s;
            end
            FN_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    cr_sh = p2_cr_reg[i] >>> FRAC_BITS;
                    v = clip32(CLIP_W'(cr_sh), s);
                    p3_side_next.res[i] = v;
                    p3_side_next.sat    = p3_side_next.sat | s;
                end
            end
            FN_ADD: begin
                for (int i = 0; i < 3; i++) begin
                    v = clip32(CLIP_W'(p2_add_reg[i]), s);
                    p3_side_next.res[i] = v;
                    p3_side_next.sat    = p3_side_next.sat | s;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
        end else if (en) begin
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_side_reg <= p3_side_next;
            p3_rad_reg  <= p2_dot_reg[63:0];
        end
    end

    // Square root of |A|^2
    logic        sq_valid;
    side_t       sq_side;
    logic [31:0] sq_root;

    v3a_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p3_valid_reg),
        .in_side   (p3_side_reg),
        .in_rad    (p3_rad_reg),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_root  (sq_root)
    );

    // Stage 4: divider operands (magnitudes; signs are fixed up at the end)
    logic               p4_valid_reg;
    side_t              p4_side_reg;
    logic [2:0][DW-1:0] p4_num_reg;
    logic [31:0]        p4_den_reg;
    side_t              p4_side_next;
    logic [2:0][DW-1:0] p4_num_next;
    logic [31:0]        p4_den_next;

    always_comb begin
        logic [31:0] mag;
        logic [15:0] dmag;
        p4_side_next      = sq_side;
        p4_side_next.root = sq_root;
        dmag = sq_side.divisor[15] ? (~sq_side.divisor + 16'd1) : sq_side.divisor;
        p4_den_next = (sq_side.func == FN_NORM) ? sq_root : 32'(dmag);
        for (int i = 0; i < 3; i++) begin
            mag = sq_side.a[i][31] ? (~sq_side.a[i] + 32'd1) : sq_side.a[i];
            if (sq_side.func == FN_NORM) begin
                p4_num_next[i] = DW'(mag) << FRAC_BITS;
            end else begin
                p4_num_next[i] = DW'(mag);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4_valid_reg <= 1'b0;
        end else if (en) begin
            p4_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p4_side_reg <= p4_side_next;
            p4_num_reg  <= p4_num_next;
            p4_den_reg  <= p4_den_next;
        end
    end

    // Divider shared by normalize and divide
    logic             dv_valid;
    side_t            dv_side;
    logic [2:0][31:0] dv_quo;

    v3a_div #(.DW(DW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p4_valid_reg),
        .in_side   (p4_side_reg),
        .in_num    (p4_num_reg),
        .in_den    (p4_den_reg),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_quo   (dv_quo)
    );

    // Output stage: sign, clip, select by opcode, status
    out_t m_data_next;

    always_comb begin
        logic               err;
        logic               sat;
        logic               s;
        logic               neg;
        logic signed [33:0] sq;
        fix_t [2:0]         r;
        fix_t               sc;
        err = 1'b0;
        sat = dv_side.sat;
        s   = 1'b0;
        neg = 1'b0;
        sq  = '0;
        r   = '0;
        sc  = '0;
        unique case (dv_side.func)
            FN_DOT: begin
                sc = dv_side.res_s;
            end
            FN_CROSS, FN_ADD: begin
                r = dv_side.res;
            end
            FN_MAG: begin
                if (dv_side.root[31]) begin
                    sc  = 32'sh7FFF_FFFF;
                    sat = 1'b1;
                end else begin
                    sc = fix_t'(dv_side.root);
                end
            end
            FN_NORM, FN_DIV: begin
                if ((dv_side.func == FN_NORM && dv_side.root == '0)
                    || (dv_side.func == FN_DIV && dv_side.divisor == '0)) begin
                    err = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        neg = dv_side.a[i][31]
                            ^ ((dv_side.func == FN_DIV) && dv_side.divisor[15]);
                        sq  = $signed({2'b00, dv_quo[i]});
                        if (neg) begin
                            sq = -sq;
                        end
                        r[i] = clip32(CLIP_W'(sq), s);
                        sat  = sat | s;
                    end
                end
            end
            default: begin
                err = 1'b1;
            end
        endcase
        if (err) begin
            m_data_next = '0;
            m_data_next.status = ST_ERR;
        end else begin
            m_data_next.result_x = r[0];
            m_data_next.result_y = r[1];
            m_data_next.result_z = r[2];
            m_data_next.scalar   = sc;
            m_data_next.status   = sat ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
